FILE: src/gcr_pkg.sv
// Package for the glyph cell rasterizer: sizes, glyph ROM, cell struct.
// Used by every module of the block and by the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

  localparam int GlyphW     = 5;
  localparam int GlyphH     = 7;
  localparam int GlyphCells = GlyphW * GlyphH;
  localparam int GlyphCount = 59;

  localparam logic [7:0] FirstCode = 8'h20;  // space
  localparam logic [7:0] LastCode  = 8'h5A;  // 'Z'

  localparam int CoordW  = 10;   // input origin, screen size
  localparam int RectW   = 11;   // output position
  localparam int AccYW   = 12;   // row position before saturation
  localparam int ScaleW  = 8;
  localparam int ColourW = 16;
  localparam int CodeW   = 8;

  localparam logic [RectW-1:0] PosMax = '1;

  localparam int ColW = $clog2(GlyphW);
  localparam int RowW = $clog2(GlyphH);

  // configuration register indexes
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenWidth  = 2'd0,
    CfgScreenHeight = 2'd1
  } cfg_idx_e;

  // rows top to bottom, MSB of each row is the leftmost column
  localparam logic [GlyphCells-1:0] GlyphRom [GlyphCount] = '{
    35'd0,                                                         // space
    {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},             // !
    35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0,
    35'd0, 35'd0, 35'd0, 35'd0, 35'd0,                             // " to ,
    {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},             // -
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04},             // .
    35'd0,                                                         // /
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},             // 0
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},             // 1
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},             // 2
    {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},             // 3
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},             // 4
    {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},             // 5
    {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},             // 6
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},             // 7
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},             // 8
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},             // 9
    {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},             // :
    35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0,                      // ; to @
    {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},             // A
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},             // B
    {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},             // C
    {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},             // D
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},             // E
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},             // F
    {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},             // G
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},             // H
    {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},             // I
    {5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E},             // J
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},             // K
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},             // L
    {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},             // M
    {5'h11, 5'h19, 5'h15, 5'h15, 5'h13, 5'h11, 5'h11},             // N
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},             // O
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},             // P
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},             // Q
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},             // R
    {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},             // S
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},             // T
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},             // U
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},             // V
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},             // W
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},             // X
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},             // Y
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}              // Z
  };

  // out-of-range codes draw as space
  function automatic logic [GlyphCells-1:0] glyph_bits(input logic [CodeW-1:0] code);
    logic [CodeW-1:0] offs;
    offs = code - FirstCode;
    if (code < FirstCode || code > LastCode) begin
      return '0;
    end
    return GlyphRom[offs[$clog2(GlyphCount)-1:0]];
  endfunction

  // one glyph cell on its way from the sequencer to the clip stage
  typedef struct packed {
    logic [RectW-1:0]   x;
    logic [AccYW-1:0]   y;
    logic [ScaleW-1:0]  size;
    logic [ColourW-1:0] colour;
    logic               last;
  } gcr_cell_t;

endpackage

`default_nettype wire

FILE: src/gcr_if.sv
// Request and rectangle channel interfaces (valid/ready plus payload).
// Depends on gcr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gcr_req_if
  import gcr_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CoordW-1:0]   origin_x;
  logic [CoordW-1:0]   origin_y;
  logic [CodeW-1:0]    char_code;
  logic [ColourW-1:0]  fore_colour;
  logic [ColourW-1:0]  back_colour;
  logic [ScaleW-1:0]   scale_factor;

  modport source (output valid, origin_x, origin_y, char_code, fore_colour,
                  back_colour, scale_factor, input ready);
  modport sink   (input valid, origin_x, origin_y, char_code, fore_colour,
                  back_colour, scale_factor, output ready);
endinterface

interface gcr_rect_if
  import gcr_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [RectW-1:0]    rect_x;
  logic [RectW-1:0]    rect_y;
  logic [ScaleW-1:0]   rect_w;
  logic [ScaleW-1:0]   rect_h;
  logic [ColourW-1:0]  rect_colour;
  logic                rect_valid;
  logic                last_cell;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_colour,
                  rect_valid, last_cell, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, rect_colour,
                  rect_valid, last_cell, output ready);
endinterface

`default_nettype wire

FILE: src/gcr_cell_seq.sv
// Request register and cell walker: holds one draw request and steps
// through its 35 glyph cells row by row. Depends on gcr_pkg, gcr_req_if.
`timescale 1ns / 1ps
`default_nettype none

module gcr_cell_seq
  import gcr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gcr_req_if.sink    req,
  output gcr_cell_t  cell_o,
  output logic       cell_valid_o,
  input  wire logic  cell_ready_i
);

  logic                  busy_q, busy_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [RectW-1:0]      x_q, x_d;
  logic [AccYW-1:0]      y_q, y_d;
  logic [CoordW-1:0]     ox_q, ox_d;
  logic [ScaleW-1:0]     scale_q, scale_d;
  logic [ColourW-1:0]    fg_q, fg_d;
  logic [ColourW-1:0]    bg_q, bg_d;
  logic [GlyphCells-1:0] glyph_q, glyph_d;

  logic last, advance, accept;

  always_comb begin
    last    = (row_q == RowW'(GlyphH - 1)) && (col_q == ColW'(GlyphW - 1));
    advance = busy_q && cell_ready_i;
    // the last cell leaving frees the register in the same cycle
    req.ready = !busy_q || (cell_ready_i && last);
    accept  = req.valid && req.ready;

    busy_d  = busy_q;
    col_d   = col_q;
    row_d   = row_q;
    x_d     = x_q;
    y_d     = y_q;
    ox_d    = ox_q;
    scale_d = scale_q;
    fg_d    = fg_q;
    bg_d    = bg_q;
    glyph_d = glyph_q;

    if (accept) begin
      busy_d  = 1'b1;
      col_d   = '0;
      row_d   = '0;
      x_d     = RectW'(req.origin_x);
      y_d     = AccYW'(req.origin_y);
      ox_d    = req.origin_x;
      scale_d = (req.scale_factor == '0) ? ScaleW'(1) : req.scale_factor;
      fg_d    = req.fore_colour;
      bg_d    = req.back_colour;
      glyph_d = glyph_bits(req.char_code);
    end else if (advance) begin
      glyph_d = {glyph_q[GlyphCells-2:0], 1'b0};
      if (last) begin
        busy_d = 1'b0;
      end else if (col_q == ColW'(GlyphW - 1)) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
        x_d   = RectW'(ox_q);
        y_d   = y_q + AccYW'(scale_q);
      end else begin
        col_d = col_q + ColW'(1);
        x_d   = x_q + RectW'(scale_q);
      end
    end

    cell_valid_o  = busy_q;
    cell_o.x      = x_q;
    cell_o.y      = y_q;
    cell_o.size   = scale_q;
    cell_o.colour = glyph_q[GlyphCells-1] ? fg_q : bg_q;
    cell_o.last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    ox_q    <= ox_d;
    scale_q <= scale_d;
    fg_q    <= fg_d;
    bg_q    <= bg_d;
    glyph_q <= glyph_d;
  end

  a_accept_busy_only_on_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && busy_q) |-> (cell_ready_i && last))
    else $error("request taken while cells still pending");

  a_idle_after_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && last && !accept) |=> !busy_q)
    else $error("walker stayed busy after last cell");

  a_first_cell_origin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> (col_q == '0 && row_q == '0 && busy_q))
    else $error("new request did not start at first cell");

endmodule

`default_nettype wire

FILE: src/gcr_rect_out.sv
// Clip stage and result register: clips one cell to the screen and holds
// the rectangle until taken. Depends on gcr_pkg, gcr_rect_if.
`timescale 1ns / 1ps
`default_nettype none

module gcr_rect_out
  import gcr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gcr_cell_t          cell_i,
  input  wire logic               cell_valid_i,
  output logic                    cell_ready_o,
  input  wire logic [CoordW-1:0]  screen_width_i,
  input  wire logic [CoordW-1:0]  screen_height_i,
  gcr_rect_if.source              rect
);

  logic                out_valid_q;
  logic [RectW-1:0]    x_q, x_d;
  logic [RectW-1:0]    y_q, y_d;
  logic [ScaleW-1:0]   w_q, w_d;
  logic [ScaleW-1:0]   h_q, h_d;
  logic [ColourW-1:0]  colour_q;
  logic                on_q, on_d;
  logic                last_q;

  logic              load;
  logic [CoordW-1:0] room_x, room_y;

  always_comb begin
    cell_ready_o = !out_valid_q || rect.ready;
    load = cell_valid_i && cell_ready_o;

    on_d = (cell_i.x < RectW'(screen_width_i)) && (cell_i.y < AccYW'(screen_height_i));
    // pixels left to the screen edge; meaningful only when on screen
    room_x = screen_width_i - cell_i.x[CoordW-1:0];
    room_y = screen_height_i - cell_i.y[CoordW-1:0];

    w_d = '0;
    h_d = '0;
    if (on_d) begin
      w_d = (CoordW'(cell_i.size) > room_x) ? room_x[ScaleW-1:0] : cell_i.size;
      h_d = (CoordW'(cell_i.size) > room_y) ? room_y[ScaleW-1:0] : cell_i.size;
    end

    x_d = cell_i.x;
    y_d = (cell_i.y > AccYW'(PosMax)) ? PosMax : cell_i.y[RectW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cell_ready_o) begin
      out_valid_q <= cell_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q      <= x_d;
      y_q      <= y_d;
      w_q      <= w_d;
      h_q      <= h_d;
      colour_q <= cell_i.colour;
      on_q     <= on_d;
      last_q   <= cell_i.last;
    end
  end

  assign rect.valid       = out_valid_q;
  assign rect.rect_x      = x_q;
  assign rect.rect_y      = y_q;
  assign rect.rect_w      = w_q;
  assign rect.rect_h      = h_q;
  assign rect.rect_colour = colour_q;
  assign rect.rect_valid  = on_q;
  assign rect.last_cell   = last_q;

  a_offscreen_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rect.valid && !rect.rect_valid) |-> (rect.rect_w == '0 && rect.rect_h == '0))
    else $error("off-screen rectangle has nonzero size");

  a_onscreen_nonempty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rect.valid && rect.rect_valid) |-> (rect.rect_w != '0 && rect.rect_h != '0))
    else $error("on-screen rectangle has zero size");

endmodule

`default_nettype wire

FILE: src/glyph_cell_rasterizer.sv
// Top level of the 5x7 glyph cell rasterizer: screen size registers,
// cell walker and clip stage. Depends on gcr_pkg, gcr_if, gcr_cell_seq, gcr_rect_out.
//
//   channel   dir  payload                                         unit
//   req_i     in   origin_x/y, char_code, fore/back_colour, scale  draw request
//   rect_o    out  rect_x/y, rect_w/h, rect_colour, valid, last    one glyph cell
//   cfg_*     in   cfg_idx_i, cfg_wdata_i                          screen size
//
// Each request yields 35 rectangles, one per cycle when rect_o is not stalled;
// the walker is the limit. The first rectangle passes the walker registers
// and then the clip stage's result register before it appears on rect_o.
// The next request is taken in the cycle its predecessor's last cell moves on.
// Reset sets the screen to 320 x 240 and empties both stages.

`timescale 1ns / 1ps
`default_nettype none

module glyph_cell_rasterizer
  import gcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gcr_req_if.sink                  req_i,
  gcr_rect_if.source               rect_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CoordW-1:0]   cfg_wdata_i
);

  logic [CoordW-1:0] screen_width_q;
  logic [CoordW-1:0] screen_height_q;

  gcr_cell_t walk_cell;
  logic      cell_valid;
  logic      cell_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= CoordW'(320);
      screen_height_q <= CoordW'(240);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScreenWidth:  screen_width_q  <= cfg_wdata_i;
        CfgScreenHeight: screen_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gcr_cell_seq u_cell_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .cell_o       (walk_cell),
    .cell_valid_o (cell_valid),
    .cell_ready_i (cell_ready)
  );

  gcr_rect_out u_rect_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cell_i          (walk_cell),
    .cell_valid_i    (cell_valid),
    .cell_ready_o    (cell_ready),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .rect            (rect_o)
  );

endmodule

`default_nettype wire
